[hw/rtl/cmet_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmet_pkg
// Shared types and codes for the CIGAR/MD edit transcript builder.
// ----------------------------------------------------------------------------
package cmet_pkg;

  localparam logic [1:0] CMD_CIGAR = 2'd0;
  localparam logic [1:0] CMD_MD    = 2'd1;
  localparam logic [1:0] CMD_PULL  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_MD_CHAR  = 3'd1;
  localparam logic [2:0] ERR_CIGAR_OP = 3'd2;
  localparam logic [2:0] ERR_DEL      = 3'd3;
  localparam logic [2:0] ERR_SPLIT    = 3'd4;
  localparam logic [2:0] ERR_LEFTOVER = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW = 3'd6;

  localparam logic [1:0] KIND_MATCH = 2'd0;
  localparam logic [1:0] KIND_MIS   = 2'd1;
  localparam logic [1:0] KIND_DEL   = 2'd2;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_X  = 8'h58;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_M  = 8'h4D;
  localparam logic [7:0] CH_I  = 8'h49;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;

  typedef enum logic [1:0] {
    MD_IDLE, MD_DIGITS, MD_LETTERS, MD_DEL
  } md_mode_t;

  // IDLE: take a transaction. MDPUSH: deferred MD run write. RD: memory read
  // in flight. STEP: decide.
  typedef enum logic [2:0] {
    ST_IDLE, ST_MDFIX, ST_PULL, ST_RD, ST_STEP, ST_OUT, ST_MDPUSH
  } state_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
  endfunction

  function automatic logic [2:0] merge_err(input logic [2:0] cur, input logic [2:0] code);
    if (code == ERR_MD_CHAR) return (cur == ERR_OK) ? ERR_MD_CHAR : cur;
    return (cur < ERR_CIGAR_OP) ? code : cur;
  endfunction

endpackage

[hw/rtl/cmet_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmet_in_if / cmet_out_if
// Valid/ready channels for command bytes and transcript symbols.
// ----------------------------------------------------------------------------
interface cmet_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_in;
  modport source (output valid, cmd, char_in, input ready);
  modport sink   (input valid, cmd, char_in, output ready);
endinterface

interface cmet_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;
  logic [2:0] error_code;
  modport source (output valid, symbol, last, error_code, input ready);
  modport sink   (input valid, symbol, last, error_code, output ready);
endinterface

[hw/rtl/cigar_md_edit_transcript.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_md_edit_transcript
// Builds an alignment edit transcript from CIGAR and MD:Z byte streams.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A CIGAR byte, an MD digit, a bad MD
// byte and a clear are handled in IDLE alone. An MD letter or '^' that opens
// a new run is written from IDLE, or from MDPUSH when it also closes a pending
// match number (the table has one write port, so the second run is written in
// the cycle after). A letter that extends the open MD run goes through MDFIX
// (read, write back). A pull passes IDLE (accept), PULL (decide) and OUT
// (load the output register), with RD (read) and STEP (decide) added for each
// step that visits a table entry: a repeated I/D/N or =/X-mode symbol visits
// none, an M symbol its MD run, and each CIGAR entry passed over (S/H ops,
// zero-length ops) adds its own visit. The op and MD tables are synchronous
// memories with one write and one read port and a registered read; the CIGAR
// cursor advances one entry per CIGAR visit, the MD cursor once its run is used up.
// The output register lets the next transaction start while a symbol waits to
// be taken; a pull that finishes its symbol holds until that register is free.
module cigar_md_edit_transcript
  import cmet_pkg::*;
#(
  parameter int MAX_CIGAR_OPS = 64,
  parameter int MAX_MD_RUNS   = 64,
  parameter int RUN_BITS      = 16
) (
  input  logic       clk,
  input  logic       rst,
  cmet_in_if.sink    in_ch,
  cmet_out_if.source out_ch
);

  localparam int CA = $clog2(MAX_CIGAR_OPS);
  localparam int MA = $clog2(MAX_MD_RUNS);
  localparam int CW = $clog2(MAX_CIGAR_OPS + 1);
  localparam int MW = $clog2(MAX_MD_RUNS + 1);
  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  // tables
  logic [8+RUN_BITS-1:0] cmem [MAX_CIGAR_OPS];
  logic [2+RUN_BITS-1:0] mmem [MAX_MD_RUNS];
  logic [8+RUN_BITS-1:0] crd;
  logic [2+RUN_BITS-1:0] mrd;
  logic          cwe, mwe;
  logic [CA-1:0] cwa, cra;
  logic [MA-1:0] mwa, mra;
  logic [8+RUN_BITS-1:0] cwd;
  logic [2+RUN_BITS-1:0] mwd;

  always_ff @(posedge clk) begin
    if (cwe) cmem[cwa] <= cwd;
    crd <= cmem[cra];
  end
  always_ff @(posedge clk) begin
    if (mwe) mmem[mwa] <= mwd;
    mrd <= mmem[mra];
  end

  state_t        state, state_next;
  logic [CW-1:0] cigar_count, cigar_count_next, cigar_cursor, cigar_cursor_next;
  logic [MW-1:0] md_count, md_count_next, md_cursor, md_cursor_next;
  logic [RUN_BITS-1:0] acc, acc_next, op_rem, op_rem_next;
  md_mode_t      mode, mode_next;
  logic          eqx, eqx_next;
  logic [2:0]    err, err_next;
  logic [7:0]    cur_op, cur_op_next;
  logic          rd_is_md, rd_is_md_next;  // STEP sees MD read, else CIGAR read
  logic          ov, ov_next;
  logic [7:0]    o_sym, o_sym_next;
  logic          o_last, o_last_next;
  logic [2:0]    o_err, o_err_next;
  logic [7:0]    s_sym, s_sym_next;        // symbol staged for the output register
  logic          s_last, s_last_next;
  logic [2:0]    s_err, s_err_next;
  logic [1:0]    push_kind, push_kind_next;  // run kind waiting for MDPUSH

  // accumulator step, widened to catch overflow
  logic [RUN_BITS+4:0] acc_mul;
  logic [RUN_BITS-1:0] acc_dig;
  logic                acc_ovf;
  always_comb begin
    acc_mul = {5'd0, acc} * (RUN_BITS+5)'(10)
            + (RUN_BITS+5)'(in_ch.char_in - CH_0);
    acc_ovf = acc_mul > {5'd0, RUN_MAX};
    acc_dig = acc_ovf ? RUN_MAX : acc_mul[RUN_BITS-1:0];
  end

  logic take;
  assign in_ch.ready = (state == ST_IDLE);
  assign take = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ov;
  assign out_ch.symbol = o_sym;
  assign out_ch.last = o_last;
  assign out_ch.error_code = o_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; cigar_count <= '0; cigar_cursor <= '0; md_count <= '0;
      md_cursor <= '0; acc <= '0; op_rem <= '0; mode <= MD_IDLE; eqx <= 1'b0;
      err <= ERR_OK; ov <= 1'b0; rd_is_md <= 1'b0;
    end else begin
      state <= state_next; cigar_count <= cigar_count_next;
      cigar_cursor <= cigar_cursor_next; md_count <= md_count_next;
      md_cursor <= md_cursor_next; acc <= acc_next; op_rem <= op_rem_next;
      mode <= mode_next; eqx <= eqx_next; err <= err_next; ov <= ov_next;
      rd_is_md <= rd_is_md_next;
    end
  end
  always_ff @(posedge clk) begin
    cur_op <= cur_op_next; o_sym <= o_sym_next; o_last <= o_last_next;
    o_err <= o_err_next; s_sym <= s_sym_next; s_last <= s_last_next;
    s_err <= s_err_next; push_kind <= push_kind_next;
  end

  logic [1:0]          mk;
  logic [RUN_BITS-1:0] mr;
  logic [7:0]          cop;
  logic [RUN_BITS-1:0] crun;
  assign mk = mrd[RUN_BITS+1:RUN_BITS];
  assign mr = mrd[RUN_BITS-1:0];
  assign cop = crd[RUN_BITS+7:RUN_BITS];
  assign crun = crd[RUN_BITS-1:0];

  always_comb begin
    logic [MW-1:0] mc;
    logic [2:0]    e;
    state_next = state; cigar_count_next = cigar_count; cigar_cursor_next = cigar_cursor;
    md_count_next = md_count; md_cursor_next = md_cursor; acc_next = acc;
    op_rem_next = op_rem; mode_next = mode; eqx_next = eqx; err_next = err;
    cur_op_next = cur_op; rd_is_md_next = rd_is_md; ov_next = ov;
    o_sym_next = o_sym; o_last_next = o_last; o_err_next = o_err;
    s_sym_next = s_sym; s_last_next = s_last; s_err_next = s_err;
    push_kind_next = push_kind;
    cwe = 1'b0; cwa = cigar_count[CA-1:0]; cwd = '0; cra = cigar_cursor[CA-1:0];
    mwe = 1'b0; mwa = md_count[MA-1:0]; mwd = '0; mra = md_cursor[MA-1:0];
    mc = md_count; e = err;
    if (ov && out_ch.ready) ov_next = 1'b0;

    // close an open MD number (CIGAR byte, MD non-digit, pull)
    if (state == ST_IDLE && take && mode == MD_DIGITS &&
        (in_ch.cmd == CMD_CIGAR || in_ch.cmd == CMD_PULL ||
         (in_ch.cmd == CMD_MD && !is_digit(in_ch.char_in)))) begin
      if (acc != '0) begin
        if (md_count >= MW'(MAX_MD_RUNS)) e = merge_err(e, ERR_OVERFLOW);
        else begin
          mwe = 1'b1; mwd = {KIND_MATCH, acc}; mc = md_count + 1'b1;
        end
      end
      acc_next = '0; mode_next = MD_IDLE;
    end

    case (state)
      ST_IDLE: if (take) begin
        case (in_ch.cmd)
          CMD_CIGAR: begin
            if (is_digit(in_ch.char_in)) begin
              // a closed MD number leaves the accumulator empty
              if (mode == MD_DIGITS) acc_next = RUN_BITS'(in_ch.char_in - CH_0);
              else begin
                acc_next = acc_dig;
                if (acc_ovf) e = merge_err(e, ERR_OVERFLOW);
              end
            end else begin
              if (in_ch.char_in == CH_X || in_ch.char_in == CH_EQ) eqx_next = 1'b1;
              if (cigar_count >= CW'(MAX_CIGAR_OPS)) e = merge_err(e, ERR_OVERFLOW);
              else begin
                cwe = 1'b1;
                cwd = {in_ch.char_in, (mode == MD_DIGITS) ? RUN_BITS'(0) : acc};
                cigar_count_next = cigar_count + 1'b1;
              end
              acc_next = '0;
            end
          end
          CMD_MD: begin
            if (is_digit(in_ch.char_in)) begin
              if (mode != MD_DIGITS) begin
                acc_next = RUN_BITS'(in_ch.char_in - CH_0);
                mode_next = MD_DIGITS;
              end else begin
                acc_next = acc_dig;
                if (acc_ovf) e = merge_err(e, ERR_OVERFLOW);
              end
            end else if (is_letter(in_ch.char_in)) begin
              if ((mode == MD_LETTERS || mode == MD_DEL) && md_count != '0) begin
                // read-modify-write the open run
                mra = MA'(md_count - 1'b1);
                state_next = ST_MDFIX;
              end else begin
                if (mwe) begin
                  // the closed number holds the write port; push next cycle
                  push_kind_next = KIND_MIS; state_next = ST_MDPUSH;
                end else if (mc >= MW'(MAX_MD_RUNS)) e = merge_err(e, ERR_OVERFLOW);
                else begin
                  mwe = 1'b1; mwa = mc[MA-1:0]; mwd = {KIND_MIS, RUN_BITS'(1)};
                  mc = mc + 1'b1;
                end
                mode_next = MD_LETTERS;
              end
            end else if (in_ch.char_in == CH_CARET) begin
              if (mwe) begin
                push_kind_next = KIND_DEL; state_next = ST_MDPUSH;
              end else if (mc >= MW'(MAX_MD_RUNS)) e = merge_err(e, ERR_OVERFLOW);
              else begin
                mwe = 1'b1; mwa = mc[MA-1:0]; mwd = {KIND_DEL, RUN_BITS'(0)};
                mc = mc + 1'b1;
              end
              mode_next = MD_DEL;
            end else begin
              mode_next = MD_IDLE;
              e = merge_err(e, ERR_MD_CHAR);
            end
          end
          CMD_PULL: state_next = ST_PULL;
          default: begin
            cigar_count_next = '0; cigar_cursor_next = '0; md_count_next = '0;
            md_cursor_next = '0; acc_next = '0; op_rem_next = '0;
            mode_next = MD_IDLE; eqx_next = 1'b0; e = ERR_OK; mc = '0;
          end
        endcase
        if (in_ch.cmd != CMD_CLEAR) md_count_next = mc;
      end
      ST_MDPUSH: begin
        if (md_count >= MW'(MAX_MD_RUNS)) e = merge_err(e, ERR_OVERFLOW);
        else begin
          mwe = 1'b1; mwa = md_count[MA-1:0];
          mwd = {push_kind, (push_kind == KIND_MIS) ? RUN_BITS'(1) : RUN_BITS'(0)};
          md_count_next = md_count + 1'b1;
        end
        state_next = ST_IDLE;
      end
      ST_MDFIX: begin
        if (mr >= RUN_MAX) e = merge_err(e, ERR_OVERFLOW);
        else begin
          mwe = 1'b1; mwa = MA'(md_count - 1'b1); mwd = mrd + 1'b1;
        end
        state_next = ST_IDLE;
      end
      ST_PULL: begin
        // choose the next step: emit a symbol or end marker, or visit a table
        if (err >= ERR_CIGAR_OP) begin
          s_sym_next = 8'd0; s_last_next = 1'b1; s_err_next = err;
          state_next = ST_OUT;
        end else if (op_rem != '0 && cigar_cursor != '0) begin
          if (eqx || cur_op == CH_I || cur_op == CH_D || cur_op == CH_N) begin
            op_rem_next = op_rem - 1'b1;
            s_sym_next = cur_op; s_last_next = 1'b0; s_err_next = err;
            state_next = ST_OUT;
          end else if (cur_op == CH_M) begin
            if (md_cursor >= md_count) op_rem_next = '0;
            else begin
              mra = md_cursor[MA-1:0]; rd_is_md_next = 1'b1; state_next = ST_RD;
            end
          end else op_rem_next = '0;
        end else if (cigar_cursor < cigar_count) begin
          cra = cigar_cursor[CA-1:0]; mra = md_cursor[MA-1:0];
          rd_is_md_next = 1'b0; state_next = ST_RD;
        end else begin
          op_rem_next = '0;
          if (!eqx && md_cursor != md_count) e = merge_err(e, ERR_LEFTOVER);
          s_sym_next = 8'd0; s_last_next = 1'b1; s_err_next = e;
          state_next = ST_OUT;
        end
      end
      ST_RD: state_next = ST_STEP;
      ST_STEP: begin
        state_next = ST_PULL;
        if (rd_is_md) begin
          if (mk > KIND_MIS) e = merge_err(e, ERR_DEL);
          else if (mr == '0) md_cursor_next = md_cursor + 1'b1;
          else if (mk == KIND_MIS && mr > op_rem) e = merge_err(e, ERR_SPLIT);
          else begin
            mwe = 1'b1; mwa = md_cursor[MA-1:0]; mwd = {mk, mr - 1'b1};
            if (mr == RUN_BITS'(1)) md_cursor_next = md_cursor + 1'b1;
            op_rem_next = op_rem - 1'b1;
            s_sym_next = (mk == KIND_MIS) ? CH_X : CH_EQ;
            s_last_next = 1'b0; s_err_next = err;
            state_next = ST_OUT;
          end
        end else begin
          cigar_cursor_next = cigar_cursor + 1'b1;
          cur_op_next = cop;
          op_rem_next = crun;
          if (!eqx) begin
            if (cop == CH_D) begin
              if (md_cursor >= md_count || mk != KIND_DEL || mr != crun) begin
                e = merge_err(e, ERR_DEL); op_rem_next = op_rem;
              end else md_cursor_next = md_cursor + 1'b1;
            end else if (cop != CH_M && cop != CH_I && cop != CH_N &&
                         cop != CH_S && cop != CH_H) begin
              e = merge_err(e, ERR_CIGAR_OP); op_rem_next = op_rem;
            end
          end
        end
      end
      ST_OUT: if (!ov || out_ch.ready) begin
        // load the output register once the previous symbol is gone
        o_sym_next = s_sym; o_last_next = s_last; o_err_next = s_err;
        ov_next = 1'b1; state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    err_next = e;
  end

endmodule

[sim/cigar_md_edit_transcript_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_md_edit_transcript_tb
// Self-checking bench: loads CIGAR and MD:Z strings, pulls the edit
// transcript and compares every symbol against a local transcript predictor.
// ----------------------------------------------------------------------------
module cigar_md_edit_transcript_tb;
  import cmet_pkg::*;

  localparam int NOPS = 64;
  localparam int NRUNS = 64;
  localparam logic [15:0] RUN_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic [2:0] err;
  } edit_sym_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cmet_in_if  in_ch();
  cmet_out_if out_ch();

  cigar_md_edit_transcript dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Transcript predictor state.
  logic [7:0]  op_chr [NOPS];
  logic [15:0] op_len [NOPS];
  logic [1:0]  run_kind [NRUNS];
  logic [15:0] run_len [NRUNS];
  int          n_ops, n_runs, op_pos, run_pos;
  logic [31:0] acc;
  md_mode_t    pmode;
  logic        eqx;
  logic [31:0] op_left;
  logic [2:0]  sticky;

  cmd_item_t pending_cmds[$];
  edit_sym_t expected_syms[$];
  int errors = 0;
  int n_syms = 0;
  int n_ends = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_send = 0;

  function automatic bit digit_ch(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit letter_ch(logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
  endfunction

  task automatic clear_model();
    n_ops = 0; n_runs = 0; op_pos = 0; run_pos = 0; acc = 0;
    pmode = MD_IDLE; eqx = 0; op_left = 0; sticky = ERR_OK;
  endtask

  function automatic void flag(logic [2:0] code);
    if (code == ERR_MD_CHAR) begin
      if (sticky == ERR_OK) sticky = ERR_MD_CHAR;
    end else if (sticky < ERR_CIGAR_OP) begin
      sticky = code;
    end
  endfunction

  function automatic void acc_digit(logic [7:0] c);
    logic [31:0] v;
    v = acc * 10 + (c - CH_0);
    if (v > RUN_MAX) begin
      flag(ERR_OVERFLOW);
      v = RUN_MAX;
    end
    acc = v;
  endfunction

  function automatic void add_run(logic [1:0] k, logic [15:0] n);
    if (n_runs >= NRUNS) begin
      flag(ERR_OVERFLOW);
    end else begin
      run_kind[n_runs] = k; run_len[n_runs] = n; n_runs++;
    end
  endfunction

  function automatic void close_number();
    if (pmode == MD_DIGITS) begin
      if (acc > 0) add_run(KIND_MATCH, acc[15:0]);
      acc = 0;
      pmode = MD_IDLE;
    end
  endfunction

  task automatic model_md(logic [7:0] c);
    if (digit_ch(c)) begin
      if (pmode != MD_DIGITS) begin
        acc = 0; pmode = MD_DIGITS;
      end
      acc_digit(c);
    end else if (letter_ch(c)) begin
      close_number();
      if ((pmode == MD_LETTERS || pmode == MD_DEL) && n_runs > 0) begin
        if (run_len[n_runs-1] >= RUN_MAX) flag(ERR_OVERFLOW);
        else run_len[n_runs-1]++;
      end else begin
        add_run(KIND_MIS, 16'd1);
        pmode = MD_LETTERS;
      end
    end else if (c == CH_CARET) begin
      close_number();
      add_run(KIND_DEL, 16'd0);
      pmode = MD_DEL;
    end else begin
      close_number();
      pmode = MD_IDLE;
      flag(ERR_MD_CHAR);
    end
  endtask

  task automatic model_cigar(logic [7:0] c);
    close_number();
    if (digit_ch(c)) begin
      acc_digit(c);
    end else begin
      if (c == CH_X || c == CH_EQ) eqx = 1;
      if (n_ops >= NOPS) begin
        flag(ERR_OVERFLOW);
      end else begin
        op_chr[n_ops] = c; op_len[n_ops] = acc[15:0]; n_ops++;
      end
      acc = 0;
    end
  endtask

  // Walk the tables to the next transcript symbol.
  function automatic edit_sym_t next_symbol();
    logic [7:0] op;
    edit_sym_t r;
    close_number();
    forever begin
      if (sticky >= ERR_CIGAR_OP) begin
        r = '{8'd0, 1'b1, sticky}; return r;
      end
      if (op_left > 0 && op_pos > 0) begin
        op = op_chr[op_pos-1];
        if (eqx || op == CH_I || op == CH_D || op == CH_N) begin
          op_left--;
          r = '{op, 1'b0, sticky}; return r;
        end
        if (op == CH_M) begin
          if (run_pos >= n_runs) begin
            op_left = 0; continue;
          end
          if (run_kind[run_pos] > KIND_MIS) begin
            flag(ERR_DEL); continue;
          end
          if (run_len[run_pos] == 0) begin
            run_pos++; continue;
          end
          if (run_kind[run_pos] == KIND_MIS && run_len[run_pos] > op_left) begin
            flag(ERR_SPLIT); continue;
          end
          run_len[run_pos]--;
          op = (run_kind[run_pos] == KIND_MIS) ? CH_X : CH_EQ;
          if (run_len[run_pos] == 0) run_pos++;
          op_left--;
          r = '{op, 1'b0, sticky}; return r;
        end
        op_left = 0;
      end else if (op_pos < n_ops) begin
        op = op_chr[op_pos];
        op_pos++;
        if (!eqx) begin
          if (op == CH_D) begin
            if (run_pos >= n_runs || run_kind[run_pos] != KIND_DEL
                || run_len[run_pos] != op_len[op_pos-1]) begin
              flag(ERR_DEL); continue;
            end
            run_pos++;
          end else if (op != CH_M && op != CH_I && op != CH_N && op != CH_S
                       && op != CH_H) begin
            flag(ERR_CIGAR_OP); continue;
          end
        end
        op_left = op_len[op_pos-1];
      end else begin
        op_left = 0;
        if (!eqx && run_pos != n_runs) flag(ERR_LEFTOVER);
        r = '{8'd0, 1'b1, sticky}; return r;
      end
    end
  endfunction

  // Driver: present the head of the queue, advance on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid   <= 1'b0;
      in_ch.cmd     <= CMD_CLEAR;
      in_ch.char_in <= 8'd0;
      clear_model();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.cmd)
          CMD_CIGAR: model_cigar(in_ch.char_in);
          CMD_MD:    model_md(in_ch.char_in);
          CMD_PULL:  expected_syms.insert(expected_syms.size(), next_symbol());
          default:   clear_model();
        endcase
        void'(pending_cmds.pop_front());
      end
      // Hold valid while the current item is not yet taken.
      if (in_ch.valid && !in_ch.ready) begin
      end else if (pending_cmds.size() > 0 && !hold_send
                   && $urandom_range(99) >= send_idle) begin
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= pending_cmds[0].cmd;
        in_ch.char_in <= pending_cmds[0].ch;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each symbol with the oldest expectation.
  always @(posedge clk) begin
    edit_sym_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_syms.size() == 0) begin
          $error("unexpected symbol %h", out_ch.symbol);
          errors++;
        end else begin
          e = expected_syms.pop_front();
          if (out_ch.symbol !== e.symbol) begin
            $error("symbol: expected %h got %h", e.symbol, out_ch.symbol); errors++;
          end
          if (out_ch.last !== e.last) begin
            $error("last: expected %b got %b", e.last, out_ch.last); errors++;
          end
          if (out_ch.error_code !== e.err) begin
            $error("error_code: expected %0d got %0d", e.err, out_ch.error_code);
            errors++;
          end
          if (e.last) n_ends++; else n_syms++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic put(logic [1:0] c, logic [7:0] ch);
    cmd_item_t it;
    it.cmd = c;
    it.ch = ch;
    pending_cmds.insert(pending_cmds.size(), it);
  endtask

  task automatic put_str(logic [1:0] c, string s);
    foreach (s[i]) put(c, s[i]);
  endtask

  task automatic put_num(logic [1:0] c, int n);
    put_str(c, $sformatf("%0d", n));
  endtask

  task automatic pull_all(int n);
    repeat (n) put(CMD_PULL, 8'd0);
  endtask

  // Record: matching CIGAR and MD with random content, maybe one random extra byte.
  task automatic rand_record();
    int nops, len, k, extra;
    logic [7:0] op;
    int mlen;
    string ltr;
    ltr = "ACGTacgt";
    put(CMD_CLEAR, 8'd0);
    nops = $urandom_range(1, 5);
    mlen = 0;
    for (int i = 0; i < nops; i++) begin
      k = $urandom_range(9);
      len = $urandom_range(1, 6);
      op = (k < 5) ? CH_M : (k == 5) ? CH_I : (k == 6) ? CH_D : (k == 7) ? CH_S : CH_N;
      put_num(CMD_CIGAR, len);
      put(CMD_CIGAR, op);
      if (op == CH_M) begin
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(3) == 0) begin
            put_num(CMD_MD, mlen);
            mlen = 0;
            put(CMD_MD, ltr[$urandom_range(7)]);
          end else begin
            mlen++;
          end
        end
      end else if (op == CH_D) begin
        put_num(CMD_MD, mlen); mlen = 0;
        put(CMD_MD, CH_CARET);
        repeat (len) put(CMD_MD, ltr[$urandom_range(3)]);
      end
    end
    put_num(CMD_MD, mlen);
    extra = $urandom_range(3);
    if (extra == 0) put(CMD_MD, 8'($urandom));
    else if (extra == 1) put(CMD_CIGAR, 8'($urandom));
    pull_all($urandom_range(1, 40));
  endtask

  task automatic noise();
    repeat ($urandom_range(1, 10)) put(2'($urandom_range(2)), 8'($urandom));
    pull_all($urandom_range(1, 8));
  endtask

  task automatic wait_drain();
    while (pending_cmds.size() != 0 || in_ch.valid || expected_syms.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: a record with a zero match run, bad MD byte, =/X mode,
    // bad op, deletion misfit, mismatch split, leftover, overflow.
    put_str(CMD_CIGAR, "3M1I2D2S1H4N2M"); put_str(CMD_MD, "0A1^AC1G"); pull_all(16);
    put(CMD_CLEAR, 8'd0); put_str(CMD_CIGAR, "2=1X1P"); put_str(CMD_MD, "9"); pull_all(6);
    put(CMD_CLEAR, 8'd0); put_str(CMD_CIGAR, "2P1M"); pull_all(2);
    put(CMD_CLEAR, 8'd0); put_str(CMD_CIGAR, "2M2D"); put_str(CMD_MD, "2^A"); pull_all(4);
    put(CMD_CLEAR, 8'd0); put_str(CMD_CIGAR, "1M"); put_str(CMD_MD, "AA"); pull_all(3);
    put(CMD_CLEAR, 8'd0); put_str(CMD_CIGAR, "1M"); put_str(CMD_MD, "1!7"); pull_all(3);
    put(CMD_CLEAR, 8'd0); put_str(CMD_CIGAR, "99999M"); pull_all(2);
    put(CMD_CLEAR, 8'd0); put(CMD_MD, 8'hFF); put(CMD_MD, 8'h00); put_str(CMD_CIGAR, "M");
    pull_all(2);
    put(CMD_CLEAR, 8'd0); repeat (66) put(CMD_CIGAR, CH_H); pull_all(2);
    put(CMD_CLEAR, 8'd0); repeat (66) put(CMD_MD, "A"); put(CMD_MD, CH_CARET); pull_all(2);
    wait_drain();

    // Random phases: no idling, sender, receiver, then both idling; drain after each.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 25 : 45) : 0;
      recv_idle = (ph == 2 || ph == 3) ? ((ph == 3) ? 25 : 45) : 0;
      for (int r = 0; r < 12; r++) begin
        if ($urandom_range(4) == 0) noise(); else rand_record();
      end
      // In phase 1 only, hold the sender once mid-phase until all symbols arrive.
      if (ph == 1) begin
        while (pending_cmds.size() >= 20) @(posedge clk);
        hold_send = 1;
        while (expected_syms.size() != 0 || in_ch.valid) @(posedge clk);
        repeat (5) @(posedge clk);
        hold_send = 0;
      end
      wait_drain();
    end

    $display("covered %0d transcript symbols and %0d end markers over all idling phases",
             n_syms, n_ends);
    if (errors == 0) begin
      $display("cigar_md_edit_transcript_tb: done, clean");
    end else begin
      $display("cigar_md_edit_transcript_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("cigar_md_edit_transcript_tb: done, errors");
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/cmet_pkg.sv
hw/rtl/cmet_if.sv
hw/rtl/cigar_md_edit_transcript.sv
sim/cigar_md_edit_transcript_tb.sv
